// ===== hw/rtl/swsu_pkg.sv =====
`default_nettype none
package swsu_pkg;

  localparam int unsigned WindowSlotsDef = 10;
  localparam int unsigned MaxPayloadDef  = 512;

  localparam logic [14:0] SeqMaxRst  = 15'd25600;
  localparam logic [14:0] StartSeqRst = 15'd0;
  localparam logic [15:0] TimeoutRst = 16'd500;

  // register indexes of the write port
  localparam logic [1:0] CfgSeqMax   = 2'd0;
  localparam logic [1:0] CfgStartSeq = 2'd1;
  localparam logic [1:0] CfgTimeout  = 2'd2;

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpOffer = 2'd1;
  localparam logic [1:0] OpAck   = 2'd2;

  localparam logic [1:0] KindSent    = 2'd0;
  localparam logic [1:0] KindRefused = 2'd1;
  localparam logic [1:0] KindRetx    = 2'd2;
  localparam logic [1:0] KindAck     = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  seg_len;
    logic [14:0] ack_num;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [14:0] seq_out;
    logic [9:0]  len_out;
    logic        last;
    logic        all_done;
  } out_word_t;

  // operand of the remainder unit
  typedef enum logic [2:0] {
    SEL_ACK  = 3'd0,
    SEL_WB   = 3'd1,
    SEL_NS   = 3'd2,
    SEL_SEQ  = 3'd3,
    SEL_BASE = 3'd4
  } rem_sel_e;

  typedef struct packed {
    logic     in_ready;
    logic     rem_start;
    rem_sel_e rem_sel;
    logic     latch_a;
    logic     latch_nb;
    logic     latch_ns;
    logic     idx_clr;
    logic     idx_inc;
    logic     tick_step;
    logic     ack_step;
    logic     ack_use_rem;
    logic     base_load;
    logic     emit_offer;
    logic     emit_tick;
    logic     emit_ack;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] op;
    logic       rem_busy;
    logic       out_free;
    logic       idx_last;
    logic       slot_busy;
    logic       slot_needs_rem;
    logic       tick_hit;
    logic       move_base;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/swsu_ctrl.sv =====
`default_nettype none
module swsu_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire swsu_pkg::sts_t sts_i,
  output swsu_pkg::cmd_t     cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_RED_A  = 13'b0000000000100,
    S_RED_NB = 13'b0000000001000,
    S_RED_NS = 13'b0000000010000,
    S_OFFER  = 13'b0000000100000,
    S_TICK   = 13'b0000001000000,
    S_TEMIT  = 13'b0000010000000,
    S_ASLOT  = 13'b0000100000000,
    S_AREM   = 13'b0001000000000,
    S_AFIN   = 13'b0010000000000,
    S_ABASE  = 13'b0100000000000,
    S_AEMIT  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rem_sel = swsu_pkg::SEL_ACK;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.accepted) state_d = S_DISP;
      end
      S_DISP: begin
        case (sts_i.op)
          swsu_pkg::OpTick: begin
            cmd_o.idx_clr = 1'b1;
            state_d = S_TICK;
          end
          swsu_pkg::OpOffer: begin
            cmd_o.rem_start = 1'b1;
            cmd_o.rem_sel   = swsu_pkg::SEL_NS;
            state_d = S_RED_NS;
          end
          swsu_pkg::OpAck: begin
            cmd_o.rem_start = 1'b1;
            cmd_o.rem_sel   = swsu_pkg::SEL_ACK;
            state_d = S_RED_A;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RED_NS: begin
        if (!sts_i.rem_busy) begin
          cmd_o.latch_ns  = 1'b1;
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_sel   = swsu_pkg::SEL_WB;
          state_d = S_RED_NB;
        end
      end
      S_RED_A: begin
        if (!sts_i.rem_busy) begin
          cmd_o.latch_a   = 1'b1;
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_sel   = swsu_pkg::SEL_WB;
          state_d = S_RED_NB;
        end
      end
      S_RED_NB: begin
        if (!sts_i.rem_busy) begin
          cmd_o.latch_nb = 1'b1;
          if (sts_i.op == swsu_pkg::OpOffer) begin
            state_d = S_OFFER;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d = S_ASLOT;
          end
        end
      end
      S_OFFER: begin
        if (sts_i.out_free) begin
          cmd_o.emit_offer = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_TEMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_TEMIT: begin
        if (!sts_i.tick_hit || sts_i.out_free) begin
          cmd_o.emit_tick = sts_i.tick_hit;
          if (sts_i.idx_last) state_d = S_IDLE;
          else cmd_o.idx_inc = 1'b1;
        end
      end
      S_ASLOT: begin
        if (sts_i.slot_busy && sts_i.slot_needs_rem) begin
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_sel   = swsu_pkg::SEL_SEQ;
          state_d = S_AREM;
        end else begin
          cmd_o.ack_step = 1'b1;
          if (sts_i.idx_last) state_d = S_AFIN;
          else cmd_o.idx_inc = 1'b1;
        end
      end
      S_AREM: begin
        if (!sts_i.rem_busy) begin
          cmd_o.ack_step    = 1'b1;
          cmd_o.ack_use_rem = 1'b1;
          if (sts_i.idx_last) begin
            state_d = S_AFIN;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = S_ASLOT;
          end
        end
      end
      S_AFIN: begin
        if (sts_i.move_base) begin
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_sel   = swsu_pkg::SEL_BASE;
          state_d = S_ABASE;
        end else begin
          state_d = S_AEMIT;
        end
      end
      S_ABASE: begin
        if (!sts_i.rem_busy) begin
          cmd_o.base_load = 1'b1;
          state_d = S_AEMIT;
        end
      end
      S_AEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ack = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/swsu_dp.sv =====
`default_nettype none
module swsu_dp #(
  parameter int unsigned WINDOW_SLOTS = swsu_pkg::WindowSlotsDef,
  parameter int unsigned MAX_PAYLOAD  = swsu_pkg::MaxPayloadDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire swsu_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output swsu_pkg::out_word_t     out_word_o,
  input  wire swsu_pkg::cmd_t     cmd_i,
  output swsu_pkg::sts_t          sts_o
);

  localparam int unsigned IW    = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned Span  = WINDOW_SLOTS * MAX_PAYLOAD;
  localparam int unsigned BestW = $clog2(Span + 32768);
  localparam int unsigned RW    = BestW + 1;
  localparam int unsigned CW    = $clog2(RW + 1);
  localparam logic [IW-1:0] IdxLast = IW'(WINDOW_SLOTS - 1);
  localparam logic [BestW-1:0] BestInit = BestW'((WINDOW_SLOTS - 1) * MAX_PAYLOAD);

  // configuration and window state
  logic [14:0] seq_max_q, start_seq_q, window_base_q, next_seq_q;
  logic [15:0] timeout_q;
  logic        source_done_q;
  logic [14:0] seq_max_d, start_seq_d, window_base_d, next_seq_d;
  logic [15:0] timeout_d;
  logic        source_done_d;

  // slot table
  logic [WINDOW_SLOTS-1:0] busy_q, busy_d, hit_q, hit_d;
  logic [15:0] age_q [WINDOW_SLOTS];
  logic [15:0] age_d [WINDOW_SLOTS];
  logic [14:0] seq_q [WINDOW_SLOTS];
  logic [9:0]  len_q [WINDOW_SLOTS];

  // per-item working registers
  logic [1:0]       op_q;
  logic [9:0]       len_in_q;
  logic [14:0]      ack_q, a_q, nb_q, ns_q;
  logic [BestW-1:0] best_q, best_d;
  logic             move_q;
  logic [IW-1:0]    idx_q, idx_d;

  // remainder unit, one quotient bit a cycle
  logic [RW-1:0] x_q, x_d;
  logic [14:0]   rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  swsu_pkg::out_word_t out_q, out_d;

  logic [15:0] modv;
  logic        accept;
  logic [9:0]  lenc;
  logic [IW-1:0] free_idx;
  logic        has_free;
  logic [15:0] dist_ns, sum_ns, rs, end_s, end_w, dist_rs, dist_a, nbm;
  logic [14:0] nb_new;
  logic        more_hits;
  logic [15:0] r2, age_inc;
  logic [RW-1:0] operand;

  assign modv   = {1'b0, seq_max_q} + 16'd1;
  assign accept = in_valid_i && cmd_i.in_ready;
  assign in_stall_o  = !cmd_i.in_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    lenc = len_in_q;
    if (32'(len_in_q) > MAX_PAYLOAD) lenc = 10'(MAX_PAYLOAD);
    free_idx = '0;
    has_free = 1'b0;
    for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx = IW'(i);
        has_free = 1'b1;
      end
    end
    more_hits = 1'b0;
    for (int j = 0; j < WINDOW_SLOTS; j++) begin
      if (IW'(j) > idx_q && hit_q[j]) more_hits = 1'b1;
    end
  end

  assign dist_ns = (ns_q >= nb_q) ? 16'(ns_q - nb_q) : 16'({1'b0, ns_q} + modv - {1'b0, nb_q});
  assign sum_ns  = {1'b0, ns_q} + 16'(lenc);
  assign rs      = cmd_i.ack_use_rem ? {1'b0, rem_q} : {1'b0, seq_q[idx_q]};
  assign end_s   = rs + 16'(len_q[idx_q]);
  assign end_w   = (end_s >= modv) ? end_s - modv : end_s;
  assign dist_rs = (rs >= {1'b0, nb_q}) ? rs - {1'b0, nb_q} : rs + modv - {1'b0, nb_q};
  // rem_q holds the reduced base while latch_nb is issued
  assign dist_a  = (a_q >= rem_q) ? 16'(a_q - rem_q) : 16'({1'b0, a_q} + modv - {1'b0, rem_q});
  assign nbm     = 16'({1'b0, rem_q} + 16'(MAX_PAYLOAD));
  assign nb_new  = (nbm >= modv) ? 15'(nbm - modv) : nbm[14:0];
  assign r2      = {rem_q, x_q[RW-1]};
  assign age_inc = (age_q[idx_q] != 16'hFFFF) ? age_q[idx_q] + 16'd1 : age_q[idx_q];

  always_comb begin
    case (cmd_i.rem_sel)
      swsu_pkg::SEL_ACK:  operand = RW'(ack_q);
      swsu_pkg::SEL_WB:   operand = RW'(window_base_q);
      swsu_pkg::SEL_NS:   operand = RW'(next_seq_q);
      swsu_pkg::SEL_SEQ:  operand = RW'(seq_q[idx_q]);
      swsu_pkg::SEL_BASE: operand = RW'(nb_q) + RW'(best_q);
      default:            operand = '0;
    endcase
  end

  always_comb begin
    seq_max_d     = seq_max_q;
    start_seq_d   = start_seq_q;
    timeout_d     = timeout_q;
    window_base_d = window_base_q;
    next_seq_d    = next_seq_q;
    source_done_d = source_done_q;
    busy_d        = busy_q;
    hit_d         = hit_q;
    age_d         = age_q;
    best_d        = best_q;
    idx_d         = idx_q;
    x_d           = x_q;
    rem_d         = rem_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        swsu_pkg::CfgSeqMax: seq_max_d = cfg_wdata_i[14:0];
        swsu_pkg::CfgStartSeq: begin
          start_seq_d   = cfg_wdata_i[14:0];
          window_base_d = cfg_wdata_i[14:0];
          next_seq_d    = cfg_wdata_i[14:0];
        end
        swsu_pkg::CfgTimeout: timeout_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (cmd_i.rem_start) begin
      x_d   = operand;
      rem_d = '0;
      cnt_d = CW'(RW);
    end else if (cnt_q != '0) begin
      x_d   = {x_q[RW-2:0], 1'b0};
      rem_d = (r2 >= modv) ? 15'(r2 - modv) : r2[14:0];
      cnt_d = cnt_q - CW'(1);
    end

    if (cmd_i.idx_clr) idx_d = '0;
    else if (cmd_i.idx_inc) idx_d = idx_q + IW'(1);

    if (cmd_i.latch_nb) best_d = BestW'(dist_a) + BestInit;

    if (cmd_i.tick_step) begin
      hit_d[idx_q] = 1'b0;
      if (busy_q[idx_q]) begin
        if (age_inc > timeout_q) begin
          age_d[idx_q] = '0;
          hit_d[idx_q] = 1'b1;
        end else begin
          age_d[idx_q] = age_inc;
        end
      end
    end

    if (cmd_i.ack_step && busy_q[idx_q]) begin
      if (end_w[14:0] == a_q) begin
        busy_d[idx_q] = 1'b0;
        age_d[idx_q]  = '0;
      end else if (BestW'(dist_rs) < best_q) begin
        best_d = BestW'(dist_rs);
      end
    end

    if (cmd_i.base_load) window_base_d = rem_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    if (cmd_i.emit_offer) begin
      out_valid_d      = 1'b1;
      out_d.kind       = swsu_pkg::KindRefused;
      out_d.slot       = '0;
      out_d.seq_out    = ns_q;
      out_d.len_out    = '0;
      out_d.last       = 1'b1;
      if (lenc == '0) begin
        source_done_d  = 1'b1;
        out_d.all_done = !(|busy_q);
      end else if (source_done_q || !has_free || 32'(dist_ns) >= Span) begin
        out_d.all_done = source_done_q && !(|busy_q);
      end else begin
        busy_d[free_idx] = 1'b1;
        age_d[free_idx]  = '0;
        next_seq_d       = (sum_ns >= modv) ? 15'(sum_ns - modv) : sum_ns[14:0];
        if (32'(lenc) < MAX_PAYLOAD) source_done_d = 1'b1;
        out_d.kind     = swsu_pkg::KindSent;
        out_d.slot     = 4'(free_idx);
        out_d.len_out  = lenc;
        out_d.all_done = 1'b0;
      end
    end

    if (cmd_i.emit_tick) begin
      out_valid_d    = 1'b1;
      out_d.kind     = swsu_pkg::KindRetx;
      out_d.slot     = 4'(idx_q);
      out_d.seq_out  = seq_q[idx_q];
      out_d.len_out  = len_q[idx_q];
      out_d.last     = !more_hits;
      out_d.all_done = source_done_q && !(|busy_q);
    end

    if (cmd_i.emit_ack) begin
      out_valid_d    = 1'b1;
      out_d.kind     = swsu_pkg::KindAck;
      out_d.slot     = '0;
      out_d.seq_out  = nb_q;
      out_d.len_out  = '0;
      out_d.last     = 1'b1;
      out_d.all_done = source_done_q && !(|busy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_max_q     <= swsu_pkg::SeqMaxRst;
      start_seq_q   <= swsu_pkg::StartSeqRst;
      timeout_q     <= swsu_pkg::TimeoutRst;
      window_base_q <= swsu_pkg::StartSeqRst;
      next_seq_q    <= swsu_pkg::StartSeqRst;
      source_done_q <= 1'b0;
      busy_q        <= '0;
      for (int i = 0; i < WINDOW_SLOTS; i++) age_q[i] <= '0;
      cnt_q         <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      seq_max_q     <= seq_max_d;
      start_seq_q   <= start_seq_d;
      timeout_q     <= timeout_d;
      window_base_q <= window_base_d;
      next_seq_q    <= next_seq_d;
      source_done_q <= source_done_d;
      busy_q        <= busy_d;
      age_q         <= age_d;
      cnt_q         <= cnt_d;
      idx_q         <= idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    best_q <= best_d;
    x_q    <= x_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
    if (accept) begin
      op_q     <= in_word_i.op;
      len_in_q <= in_word_i.seg_len;
      ack_q    <= in_word_i.ack_num;
    end
    if (cmd_i.latch_a)  a_q  <= rem_q;
    if (cmd_i.latch_ns) ns_q <= rem_q;
    if (cmd_i.latch_nb) begin
      nb_q   <= rem_q;
      move_q <= (a_q == nb_new);
    end
    if (cmd_i.base_load) nb_q <= rem_q;
    if (cmd_i.emit_offer && lenc != '0 && !source_done_q && has_free
        && 32'(dist_ns) < Span) begin
      seq_q[free_idx] <= ns_q;
      len_q[free_idx] <= lenc;
    end
  end

  always_comb begin
    sts_o = '0;
    sts_o.accepted       = accept;
    sts_o.op             = op_q;
    sts_o.rem_busy       = (cnt_q != '0);
    sts_o.out_free       = !out_valid_q || !out_stall_i;
    sts_o.idx_last       = (idx_q == IdxLast);
    sts_o.slot_busy      = busy_q[idx_q];
    sts_o.slot_needs_rem = ({1'b0, seq_q[idx_q]} >= modv);
    sts_o.tick_hit       = hit_q[idx_q];
    sts_o.move_base      = move_q;
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_offer || cmd_i.emit_tick || cmd_i.emit_ack) |-> sts_o.out_free)
    else $error("word emitted while output register held");

  a_rem_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rem_start |-> (cnt_q == '0))
    else $error("remainder unit restarted while busy");

  a_base_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.base_load |=> ({1'b0, window_base_q} < modv))
    else $error("window base not reduced");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> !accept)
    else $error("item taken during remainder run");

endmodule
`default_nettype wire

// ===== hw/rtl/sliding_window_sender_unit.sv =====
`default_nettype none
// Sender window bookkeeping for a selective-repeat transfer.
// Input words (op, seg_len, ack_num) arrive on in_valid_i / in_stall_o and
// are taken one at a time; in_stall_o is high while a word is in work.
// Result words leave on out_valid_o / out_stall_i through one output
// register: a tick gives one word per expired slot (none if nothing
// expired), an offer or an ack gives exactly one; last marks the final one.
// A shared remainder unit of RW = clog2(slots*payload + 32768) + 1 steps
// (17 at defaults) reduces each operand modulo seq_max+1, one bit a cycle.
// A tick walks the slots once to age them and once to emit the expired ones.
// An offer reduces the next sequence and the window base; an ack reduces the
// ack number, the window base, each busy slot sequence above seq_max and a moved base.
// While the receiver stalls, the unit holds the pending word and waits.
// Reset clears the slots and loads the default registers; the window base
// and next sequence take start_seq, also on every write of start_seq.
// Register writes must be made only while no word is in work; the unit
// itself does not enforce this.
module sliding_window_sender_unit #(
  parameter int unsigned WINDOW_SLOTS = swsu_pkg::WindowSlotsDef,
  parameter int unsigned MAX_PAYLOAD  = swsu_pkg::MaxPayloadDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire swsu_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output swsu_pkg::out_word_t     out_word_o
);

  swsu_pkg::cmd_t cmd;
  swsu_pkg::sts_t sts;

  swsu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  swsu_dp #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire
